/* design/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// antecedent on this edge implies consequent on the next
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/vpsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vpsi_pkg;

	localparam int DEF_MAX_X = 64;
	localparam int DEF_MAX_Y = 64;
	localparam int DEF_MAX_Z = 64;

	localparam int DATA_W = 32;
	localparam int DIM_W = 7;
	localparam int APB_AW = 4;

	localparam logic [1:0] REG_DIM_X = 2'd0;
	localparam logic [1:0] REG_DIM_Y = 2'd1;
	localparam logic [1:0] REG_DIM_Z = 2'd2;

	typedef struct packed {
		logic has_x;
		logic has_y;
		logic has_z;
		logic last;
		logic sel;
	} flags_t;

endpackage

`default_nettype wire

/* design/vpsi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module vpsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* design/vpsi_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vpsi_seq #(
	parameter int MAX_X = vpsi_pkg::DEF_MAX_X,
	parameter int MAX_Y = vpsi_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vpsi_pkg::DEF_MAX_Z,
	localparam int AW = (MAX_Y * MAX_Z > 1) ? $clog2(MAX_Y * MAX_Z) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vpsi_pkg::APB_AW-1:0] paddr,
	input  wire logic [vpsi_pkg::DATA_W-1:0] pwdata,
	output logic      [vpsi_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        advance,
	output logic      [AW-1:0]               addr_cur,
	output logic      [AW-1:0]               addr_up,
	output vpsi_pkg::flags_t                 flags
);

	localparam int XPW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YPW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZPW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int XEW = $clog2(MAX_X + 1);
	localparam int YEW = $clog2(MAX_Y + 1);
	localparam int ZEW = $clog2(MAX_Z + 1);

	logic [vpsi_pkg::DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;
	logic [XPW-1:0] pos_x_q;
	logic [YPW-1:0] pos_y_q;
	logic [ZPW-1:0] pos_z_q;
	logic plane_sel_q;
	logic [XEW-1:0] eff_x;
	logic [YEW-1:0] eff_y;
	logic [ZEW-1:0] eff_z;
	logic last_x, last_y, last_z;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		if (dim_x_q == '0) eff_x = XEW'(1);
		else if (32'(dim_x_q) > MAX_X) eff_x = XEW'(MAX_X);
		else eff_x = XEW'(dim_x_q);
		if (dim_y_q == '0) eff_y = YEW'(1);
		else if (32'(dim_y_q) > MAX_Y) eff_y = YEW'(MAX_Y);
		else eff_y = YEW'(dim_y_q);
		if (dim_z_q == '0) eff_z = ZEW'(1);
		else if (32'(dim_z_q) > MAX_Z) eff_z = ZEW'(MAX_Z);
		else eff_z = ZEW'(dim_z_q);
	end

	assign last_x = (XEW'(pos_x_q) == eff_x - XEW'(1));
	assign last_y = (YEW'(pos_y_q) == eff_y - YEW'(1));
	assign last_z = (ZEW'(pos_z_q) == eff_z - ZEW'(1));

	always_comb begin
		case (paddr[3:2])
			vpsi_pkg::REG_DIM_X: prdata = vpsi_pkg::DATA_W'(dim_x_q);
			vpsi_pkg::REG_DIM_Y: prdata = vpsi_pkg::DATA_W'(dim_y_q);
			vpsi_pkg::REG_DIM_Z: prdata = vpsi_pkg::DATA_W'(dim_z_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= vpsi_pkg::DIM_W'(1);
			dim_y_q <= vpsi_pkg::DIM_W'(1);
			dim_z_q <= vpsi_pkg::DIM_W'(1);
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			plane_sel_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				vpsi_pkg::REG_DIM_X: dim_x_q <= pwdata[vpsi_pkg::DIM_W-1:0];
				vpsi_pkg::REG_DIM_Y: dim_y_q <= pwdata[vpsi_pkg::DIM_W-1:0];
				vpsi_pkg::REG_DIM_Z: dim_z_q <= pwdata[vpsi_pkg::DIM_W-1:0];
				default: ;
			endcase
			if (paddr[3:2] == vpsi_pkg::REG_DIM_X || paddr[3:2] == vpsi_pkg::REG_DIM_Y ||
				paddr[3:2] == vpsi_pkg::REG_DIM_Z) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				plane_sel_q <= 1'b0;
			end
		end else if (advance) begin
			if (!last_z) begin
				pos_z_q <= pos_z_q + ZPW'(1);
			end else begin
				pos_z_q <= '0;
				if (!last_y) begin
					pos_y_q <= pos_y_q + YPW'(1);
				end else begin
					pos_y_q <= '0;
					if (!last_x) begin
						pos_x_q <= pos_x_q + XPW'(1);
						plane_sel_q <= !plane_sel_q;
					end else begin
						pos_x_q <= '0;
						plane_sel_q <= 1'b0;
					end
				end
			end
		end
	end

	assign addr_cur = AW'(pos_y_q) * AW'(MAX_Z) + AW'(pos_z_q);
	assign addr_up = addr_cur - AW'(MAX_Z);

	assign flags.has_x = (pos_x_q != '0);
	assign flags.has_y = (pos_y_q != '0);
	assign flags.has_z = (pos_z_q != '0);
	assign flags.last = last_x && last_y && last_z;
	assign flags.sel = plane_sel_q;

	`ASSERT_HOLDS(a_z_in_row, clk, arst_n, ZEW'(pos_z_q) < eff_z, "z position past row end")
	`ASSERT_NEXT(a_restart, clk, arst_n, advance && flags.last && !cfg_wr,
		pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0 && !plane_sel_q,
		"counters did not restart after volume end")

endmodule

`default_nettype wire

/* design/vpsi_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vpsi_calc (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic signed [vpsi_pkg::DATA_W-1:0] cumulative_value,
	input  wire vpsi_pkg::flags_t                  flags,
	input  wire logic        [vpsi_pkg::DATA_W-1:0] rd0_a,
	input  wire logic        [vpsi_pkg::DATA_W-1:0] rd0_b,
	input  wire logic        [vpsi_pkg::DATA_W-1:0] rd1_a,
	input  wire logic        [vpsi_pkg::DATA_W-1:0] rd1_b,
	output logic                                   in_stall,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed      [vpsi_pkg::DATA_W-1:0] element_value,
	output logic                                   volume_end
);

	logic valid_s1;
	logic [vpsi_pkg::DATA_W-1:0] c_s1;
	vpsi_pkg::flags_t flags_s1;
	logic [vpsi_pkg::DATA_W-1:0] prev_p_q;
	logic out_valid_q;
	logic [vpsi_pkg::DATA_W-1:0] elem_q;
	logic vend_q;
	logic out_free, fire_s1;
	logic [vpsi_pkg::DATA_W-1:0] up, back, backup, p, e;

	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1 = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// up from current plane, back terms from the other plane
	always_comb begin
		up = flags_s1.sel ? rd1_b : rd0_b;
		back = flags_s1.sel ? rd0_a : rd1_a;
		backup = flags_s1.sel ? rd0_b : rd1_b;
		if (!flags_s1.has_y) up = '0;
		if (!flags_s1.has_x) back = '0;
		if (!(flags_s1.has_x && flags_s1.has_y)) backup = '0;
		p = c_s1 - back - up + backup;
		e = p - (flags_s1.has_z ? prev_p_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			prev_p_q <= '0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (fire_s1) valid_s1 <= 1'b0;
			if (out_free) out_valid_q <= valid_s1;
			if (fire_s1) prev_p_q <= p;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1 <= cumulative_value;
			flags_s1 <= flags;
		end
		if (fire_s1) begin
			elem_q <= e;
			vend_q <= flags_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign element_value = elem_q;
	assign volume_end = vend_q;

	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_free,
		valid_s1 && $stable(c_s1), "blocked stage lost its beat")
	`ASSERT_NEXT(a_s1_to_out, clk, arst_n, fire_s1, out_valid_q,
		"beat left stage one but output is empty")

endmodule

`default_nettype wire

/* design/volume_prefix_sum_inverse_top.sv */
// Inverse 3D summed-volume table.
// Input channel (in_valid/in_stall, cumulative_value): cumulative sums in raster
// order, z fastest, then y, then x. Output channel (out_valid/out_stall,
// element_value, volume_end): one recovered element per input beat, volume_end
// set on the last beat of each volume; counters then restart.
// A taken beat is held in the read stage registers, then in the output register.
// Throughput: one beat per cycle unless the output stalls. Two plane RAMs, each
// with one write and two read ports; the current plane is read and written.
// When the receiver stalls, the output register holds and one more beat can sit
// in the read stage; after that in_stall rises in the same cycle.
// Configuration via APB at 0x0 dim_x, 0x4 dim_y, 0x8 dim_z (1..MAX, 0 acts as 1,
// larger values saturate); a write restarts the volume. Write only when idle.
// Reset (arst_n low): dimensions become 1, positions clear, pipeline empties.
// Plane RAM content is not cleared; only entries written in the current volume
// are used, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module volume_prefix_sum_inverse_top #(
	parameter int MAX_X = vpsi_pkg::DEF_MAX_X,
	parameter int MAX_Y = vpsi_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vpsi_pkg::DEF_MAX_Z
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [vpsi_pkg::APB_AW-1:0] paddr,
	input  wire logic        [vpsi_pkg::DATA_W-1:0] pwdata,
	output logic             [vpsi_pkg::DATA_W-1:0] prdata,
	output logic                                    pready,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [vpsi_pkg::DATA_W-1:0] cumulative_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed      [vpsi_pkg::DATA_W-1:0] element_value,
	output logic                                    volume_end
);

	localparam int DEPTH = MAX_Y * MAX_Z;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic accept;
	logic [AW-1:0] addr_cur, addr_up;
	logic [AW-1:0] raddr0_a, raddr1_a;
	vpsi_pkg::flags_t flags;
	logic [vpsi_pkg::DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

	assign accept = in_valid && !in_stall;
	assign raddr0_a = flags.sel ? addr_cur : addr_up;
	assign raddr1_a = flags.sel ? addr_up : addr_cur;

	vpsi_seq #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y),
		.MAX_Z(MAX_Z)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.advance(accept),
		.addr_cur(addr_cur),
		.addr_up(addr_up),
		.flags(flags)
	);

	vpsi_ram #(
		.WIDTH(vpsi_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_plane0 (
		.clk(clk),
		.we(accept && !flags.sel),
		.waddr(addr_cur),
		.wdata(cumulative_value),
		.re(accept),
		.raddr_a(raddr0_a),
		.raddr_b(addr_up),
		.rdata_a(rd0_a),
		.rdata_b(rd0_b)
	);

	vpsi_ram #(
		.WIDTH(vpsi_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_plane1 (
		.clk(clk),
		.we(accept && flags.sel),
		.waddr(addr_cur),
		.wdata(cumulative_value),
		.re(accept),
		.raddr_a(raddr1_a),
		.raddr_b(addr_up),
		.rdata_a(rd1_a),
		.rdata_b(rd1_b)
	);

	vpsi_calc u_calc (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cumulative_value(cumulative_value),
		.flags(flags),
		.rd0_a(rd0_a),
		.rd0_b(rd0_b),
		.rd1_a(rd1_a),
		.rd1_b(rd1_b),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element_value(element_value),
		.volume_end(volume_end)
	);

endmodule

`default_nettype wire
